@@ rtl/core/frg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frg_pkg: shared definitions for the fraction reduction block
// widths and payload types used by the channel interfaces and the core
// ----------------------------------------------------------------------------
package frg_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic signed [WIDTH-1:0] sword_t;
  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

endpackage

@@ rtl/core/frg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frg_if: valid/ready channels of the fraction reduction block
// frg_in_if carries the fraction in, frg_out_if the reduced fraction out
// ----------------------------------------------------------------------------
interface frg_in_if import frg_pkg::*; ();
  logic   valid;
  logic   ready;
  sword_t numerator;
  sword_t denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink (input valid, input numerator, input denominator, output ready);
endinterface

interface frg_out_if import frg_pkg::*; ();
  logic   valid;
  logic   ready;
  sword_t reduced_numerator;
  sword_t reduced_denominator;
  logic   zero_denominator;

  modport source (
    output valid, output reduced_numerator, output reduced_denominator,
    output zero_denominator, input ready
  );
  modport sink (
    input valid, input reduced_numerator, input reduced_denominator,
    input zero_denominator, output ready
  );
endinterface

@@ rtl/core/fraction_reduce_gcd.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_reduce_gcd: reduces a signed fraction to lowest terms
// binary gcd and two restoring divisions on one shared subtractor
// ----------------------------------------------------------------------------
// One fraction is worked on at a time; in_ch.ready is high only while the
// sequencer is idle, and a finished result sits in the output register so the
// next fraction can be taken while it waits. A zero numerator gives 0/1 and a
// zero denominator passes the fraction through with zero_denominator set.
// Otherwise the work runs on the one WIDTH+1 bit subtractor: a data-dependent
// binary gcd phase (common twos removed, then one shift, swap or subtract per
// cycle) followed by the two divisions.
// Apart from a zero denominator, the result denominator is a magnitude and
// the sign sits on the numerator.
module fraction_reduce_gcd import frg_pkg::*; (
  input logic clk,
  input logic rst_n,
  frg_in_if.sink in_ch,
  frg_out_if.source out_ch
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TWOS = 7'b0000010,
    S_AODD = 7'b0000100,
    S_LOOP = 7'b0001000,
    S_DIVN = 7'b0010000,
    S_DIVD = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  word_t  a_r, a_nxt;
  word_t  b_r, b_nxt;
  word_t  n_r, n_nxt;
  word_t  d_r, d_nxt;
  word_t  q_r, q_nxt;
  word_t  rem_r, rem_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   neg_r, neg_nxt;
  logic   zflag_r, zflag_nxt;

  logic   ovalid_r, ovalid_nxt;
  sword_t onum_r, onum_nxt;
  sword_t oden_r, oden_nxt;
  logic   ozero_r, ozero_nxt;

  word_t             num_mag, den_mag;
  logic [WIDTH:0]    sub_x, diff;
  logic              borrow;
  word_t             q_step, rem_step;

  // shared subtractor
  assign sub_x  = (state_r == S_LOOP) ? {1'b0, b_r} : {rem_r, q_r[WIDTH-1]};
  assign diff   = sub_x - {1'b0, a_r};
  assign borrow = diff[WIDTH];

  // restoring division step
  assign q_step   = {q_r[WIDTH-2:0], ~borrow};
  assign rem_step = borrow ? sub_x[WIDTH-1:0] : diff[WIDTH-1:0];

  assign num_mag = in_ch.numerator[WIDTH-1] ? word_t'(-in_ch.numerator)
                                            : word_t'(in_ch.numerator);
  assign den_mag = in_ch.denominator[WIDTH-1] ? word_t'(-in_ch.denominator)
                                              : word_t'(in_ch.denominator);

  assign in_ch.ready                = (state_r == S_IDLE);
  assign out_ch.valid               = ovalid_r;
  assign out_ch.reduced_numerator   = onum_r;
  assign out_ch.reduced_denominator = oden_r;
  assign out_ch.zero_denominator    = ozero_r;

  always_comb begin
    state_nxt  = state_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    n_nxt      = n_r;
    d_nxt      = d_r;
    q_nxt      = q_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    zflag_nxt  = zflag_r;
    ovalid_nxt = ovalid_r;
    onum_nxt   = onum_r;
    oden_nxt   = oden_r;
    ozero_nxt  = ozero_r;

    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.numerator == '0) begin
            n_nxt     = '0;
            d_nxt     = word_t'(1);
            neg_nxt   = 1'b0;
            zflag_nxt = 1'b0;
            state_nxt = S_DONE;
          end else if (in_ch.denominator == '0) begin
            n_nxt     = word_t'(in_ch.numerator);
            d_nxt     = '0;
            neg_nxt   = 1'b0;
            zflag_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            n_nxt     = num_mag;
            d_nxt     = den_mag;
            a_nxt     = num_mag;
            b_nxt     = den_mag;
            neg_nxt   = in_ch.numerator[WIDTH-1] ^ in_ch.denominator[WIDTH-1];
            zflag_nxt = 1'b0;
            state_nxt = S_TWOS;
          end
        end
      end
      S_TWOS: begin
        // common factors of two divide everything
        if (a_r[0] || b_r[0]) begin
          state_nxt = S_AODD;
        end else begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          n_nxt = n_r >> 1;
          d_nxt = d_r >> 1;
        end
      end
      S_AODD: begin
        if (a_r[0]) begin
          state_nxt = S_LOOP;
        end else begin
          a_nxt = a_r >> 1;
        end
      end
      S_LOOP: begin
        if (b_r == '0) begin
          q_nxt     = n_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIVN;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (borrow) begin
          a_nxt = b_r;
          b_nxt = a_r;
        end else begin
          b_nxt = diff[WIDTH-1:0];
        end
      end
      S_DIVN: begin
        q_nxt   = q_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + cnt_t'(1);
        if (cnt_r == cnt_t'(WIDTH - 1)) begin
          n_nxt     = q_step;
          q_nxt     = d_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        q_nxt   = q_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + cnt_t'(1);
        if (cnt_r == cnt_t'(WIDTH - 1)) begin
          d_nxt     = q_step;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_r || out_ch.ready) begin
          ovalid_nxt = 1'b1;
          onum_nxt   = neg_r ? sword_t'(-n_r) : sword_t'(n_r);
          oden_nxt   = sword_t'(d_r);
          ozero_nxt  = zflag_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    zflag_r <= zflag_nxt;
    onum_r  <= onum_nxt;
    oden_r  <= oden_nxt;
    ozero_r <= ozero_nxt;
  end

endmodule
